// ----- sv/nct_pkg.sv -----
// Shared types, widths and register codes of the nearest covering triangle search.
package nct_pkg;

  // Coordinate format: signed fixed point, 8 fractional bits
  localparam int FieldW      = 32;
  localparam int CoordBits   = 32;
  localparam int DiffW       = CoordBits + 1;
  localparam int ProdW       = 2 * DiffW;
  localparam int CrossW      = ProdW + 1;
  localparam int SumW        = CoordBits + 4;
  localparam int DistW       = 35;

  // Triangle counting
  localparam int MaxTriangles = 1024;
  localparam int CntW         = $clog2(MaxTriangles + 1);
  localparam int PosW         = 10;

  // Stream and register port widths
  localparam int InDataW  = 9 * FieldW;
  localparam int OutDataW = 16;
  localparam int AddrW    = 4;
  localparam int RegW     = 32;

  // Register indexes (byte address / 4)
  typedef enum logic [1:0] {
    REG_QUERY_X = 2'd0,
    REG_QUERY_Y = 2'd1,
    REG_QUERY_Z = 2'd2
  } nct_reg_e;

  typedef logic signed [CoordBits-1:0] coord_t;

  // One triangle and its end-of-query mark
  typedef struct packed {
    coord_t a_x;
    coord_t a_y;
    coord_t a_z;
    coord_t b_x;
    coord_t b_y;
    coord_t b_z;
    coord_t c_x;
    coord_t c_y;
    coord_t c_z;
    logic   last;
  } tri_t;

  // Query point
  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } query_t;

  // Per-triangle verdict handed to the selection stage
  typedef struct packed {
    logic             hit;
    logic [DistW-1:0] gap;
    logic             last;
  } cover_t;

endpackage

// ----- sv/nct_cover.sv -----
// Three-stage coverage test and height distance pipeline for one triangle per cycle unless stalled.
module nct_cover (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nct_pkg::query_t query_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  nct_pkg::tri_t   tri_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output nct_pkg::cover_t out_o
);
  import nct_pkg::*;

  typedef logic signed [DiffW-1:0] diff_t;
  typedef logic signed [ProdW-1:0] prod_t;
  typedef logic signed [CrossW-1:0] cross_t;

  function automatic diff_t sub_coord(coord_t a, coord_t b);
    diff_t ea;
    diff_t eb;
    ea = diff_t'(a);
    eb = diff_t'(b);
    return ea - eb;
  endfunction

  function automatic logic cross_pos(prod_t p, prod_t q);
    cross_t c;
    c = cross_t'(p) - cross_t'(q);
    return !c[CrossW-1] && (c != '0);
  endfunction

  // Stage 1: edge and offset vectors, height difference
  logic                   v1_q;
  diff_t                  bax_q, baz_q, cax_q, caz_q, pax_q, paz_q;
  diff_t                  cbx_q, cbz_q, pbx_q, pbz_q;
  logic signed [SumW-1:0] ydiff_q;
  logic                   last1_q;

  // Stage 2: products and distance magnitude
  logic             v2_q;
  prod_t            p_ab0_q, p_ab1_q, p_ac0_q, p_ac1_q, p_bc0_q, p_bc1_q;
  logic [DistW-1:0] dist2_q;
  logic             last2_q;

  // Stage 3: coverage verdict
  logic   v3_q;
  cover_t out_q;

  logic rdy1, rdy2, rdy3;
  logic signed [SumW-1:0] ysum;
  logic signed [SumW-1:0] py3;
  logic [SumW-1:0]        ymag;
  logic s_ab, s_ac, s_bc;

  // Stall chain: a stage moves when the one after it has room
  assign rdy3       = !v3_q || out_ready_i;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1;

  assign py3  = (SumW'(query_i.y) <<< 1) + SumW'(query_i.y);
  assign ysum = SumW'(tri_i.a_y) + SumW'(tri_i.b_y) + SumW'(tri_i.c_y);
  assign ymag = ydiff_q[SumW-1] ? (SumW'(0) - ydiff_q) : ydiff_q;

  assign s_ab = cross_pos(p_ab0_q, p_ab1_q);
  assign s_ac = cross_pos(p_ac0_q, p_ac1_q);
  assign s_bc = cross_pos(p_bc0_q, p_bc1_q);

  // Valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_valid_i;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (rdy1) begin
      bax_q   <= sub_coord(tri_i.b_x, tri_i.a_x);
      baz_q   <= sub_coord(tri_i.b_z, tri_i.a_z);
      cax_q   <= sub_coord(tri_i.c_x, tri_i.a_x);
      caz_q   <= sub_coord(tri_i.c_z, tri_i.a_z);
      pax_q   <= sub_coord(query_i.x, tri_i.a_x);
      paz_q   <= sub_coord(query_i.z, tri_i.a_z);
      cbx_q   <= sub_coord(tri_i.c_x, tri_i.b_x);
      cbz_q   <= sub_coord(tri_i.c_z, tri_i.b_z);
      pbx_q   <= sub_coord(query_i.x, tri_i.b_x);
      pbz_q   <= sub_coord(query_i.z, tri_i.b_z);
      ydiff_q <= py3 - ysum;
      last1_q <= tri_i.last;
    end
    if (rdy2) begin
      p_ab0_q <= bax_q * paz_q;
      p_ab1_q <= baz_q * pax_q;
      p_ac0_q <= cax_q * paz_q;
      p_ac1_q <= caz_q * pax_q;
      p_bc0_q <= cbx_q * pbz_q;
      p_bc1_q <= cbz_q * pbx_q;
      dist2_q <= DistW'(ymag);
      last2_q <= last1_q;
    end
    if (rdy3) begin
      out_q.hit  <= (s_ac != s_ab) && (s_bc == s_ab);
      out_q.gap  <= dist2_q;
      out_q.last <= last2_q;
    end
  end

  assign out_valid_o = v3_q;
  assign out_o       = out_q;

endmodule

// ----- sv/nearest_covering_triangle_search.sv -----
// Nearest covering triangle search: top level with register port, selection and result register.
// Triangles stream in one per cycle on the s_axis side unless stalled; each is tested for covering
// the query point in the XZ plane, and among covering triangles the one whose average vertex height
// lies closest to query_y is kept (ties keep the earlier one). The transaction that carries tlast
// closes the query: one result goes out on m_axis with found in tuser and the stream position
// of the best triangle in tdata, and the search state clears. Throughput is one triangle per
// cycle unless stalled; a closing triangle passes the difference, multiply, sign and result
// registers in turn before its result is valid, the multiply stage with its six 33 by 33 bit
// products setting the clock. Only the first 1024 triangles of a query count. Write the query
// registers only while no triangle is in flight.
module nearest_covering_triangle_search (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Triangle stream. tdata from bit 0: a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [nct_pkg::InDataW-1:0]    s_axis_tdata,
  input  logic                           s_axis_tlast,
  // Result stream. tdata from bit 0: best_index, zero padded; tuser: found
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [nct_pkg::OutDataW-1:0]   m_axis_tdata,
  output logic                           m_axis_tuser,
  // Register port
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [nct_pkg::AddrW-1:0]      paddr,
  input  logic [nct_pkg::RegW-1:0]       pwdata,
  output logic [nct_pkg::RegW-1:0]       prdata,
  output logic                           pready
);
  import nct_pkg::*;

  logic [RegW-1:0] query_x_q, query_y_q, query_z_q;
  nct_reg_e        reg_idx;
  logic            reg_wr;
  query_t          query;
  tri_t            tri_in;

  cover_t          cov;
  logic            cov_valid;
  logic            cov_ready;
  logic            take;

  logic [DistW-1:0] best_dist_q, best_dist_d;
  logic [PosW-1:0]  best_pos_q, best_pos_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             any_q, any_d;
  logic             counting, better;
  logic             upd_any;
  logic [PosW-1:0]  upd_pos;

  logic             out_valid_q;
  logic             out_found_q;
  logic [PosW-1:0]  out_idx_q;

  // Register port decode
  assign pready  = 1'b1;
  assign reg_idx = nct_reg_e'(paddr[AddrW-1:2]);
  assign reg_wr  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      query_x_q <= '0;
      query_y_q <= '0;
      query_z_q <= '0;
    end else if (reg_wr) begin
      case (reg_idx)
        REG_QUERY_X: query_x_q <= pwdata;
        REG_QUERY_Y: query_y_q <= pwdata;
        REG_QUERY_Z: query_z_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_QUERY_X: prdata = query_x_q;
      REG_QUERY_Y: prdata = query_y_q;
      REG_QUERY_Z: prdata = query_z_q;
      default:     prdata = '0;
    endcase
  end

  // Unpack the query point and the triangle
  assign query.x = query_x_q[CoordBits-1:0];
  assign query.y = query_y_q[CoordBits-1:0];
  assign query.z = query_z_q[CoordBits-1:0];

  assign tri_in.a_x  = s_axis_tdata[0*FieldW +: CoordBits];
  assign tri_in.a_y  = s_axis_tdata[1*FieldW +: CoordBits];
  assign tri_in.a_z  = s_axis_tdata[2*FieldW +: CoordBits];
  assign tri_in.b_x  = s_axis_tdata[3*FieldW +: CoordBits];
  assign tri_in.b_y  = s_axis_tdata[4*FieldW +: CoordBits];
  assign tri_in.b_z  = s_axis_tdata[5*FieldW +: CoordBits];
  assign tri_in.c_x  = s_axis_tdata[6*FieldW +: CoordBits];
  assign tri_in.c_y  = s_axis_tdata[7*FieldW +: CoordBits];
  assign tri_in.c_z  = s_axis_tdata[8*FieldW +: CoordBits];
  assign tri_in.last = s_axis_tlast;

  nct_cover u_cover (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .query_i     (query),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .tri_i       (tri_in),
    .out_valid_o (cov_valid),
    .out_ready_i (cov_ready),
    .out_o       (cov)
  );

  // Select stage: a closing triangle waits only while the result register is full and not being taken
  assign cov_ready = !cov.last || !out_valid_q || m_axis_tready;
  assign take      = cov_valid && cov_ready;
  assign counting  = cnt_q < CntW'(MaxTriangles);
  assign better    = counting && cov.hit && (!any_q || (cov.gap < best_dist_q));
  assign upd_any   = any_q || better;
  assign upd_pos   = better ? cnt_q[PosW-1:0] : best_pos_q;

  always_comb begin
    best_dist_d = best_dist_q;
    best_pos_d  = best_pos_q;
    any_d       = any_q;
    cnt_d       = cnt_q;
    if (take) begin
      if (cov.last) begin
        // Close the query: clear the search
        best_dist_d = '0;
        best_pos_d  = '0;
        any_d       = 1'b0;
        cnt_d       = '0;
      end else begin
        if (better) best_dist_d = cov.gap;
        best_pos_d = upd_pos;
        any_d      = upd_any;
        if (counting) cnt_d = cnt_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_dist_q <= '0;
      best_pos_q  <= '0;
      any_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      best_dist_q <= best_dist_d;
      best_pos_q  <= best_pos_d;
      any_q       <= any_d;
      cnt_q       <= cnt_d;
    end
  end

  // Result register: load on a closing triangle, drop once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && cov.last) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && cov.last) begin
      out_found_q <= upd_any;
      out_idx_q   <= upd_any ? upd_pos : '0;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_found_q;
  assign m_axis_tdata  = OutDataW'(out_idx_q);

  // Checks
  a_no_index_without_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata == '0)
    else $error("result without a hit carries a nonzero index");

  a_count_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MaxTriangles))
    else $error("triangle counter beyond its limit");

  a_pos_clear_without_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !any_q |-> best_pos_q == '0)
    else $error("best position set while no hit is recorded");

  a_clear_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && cov.last |=> cnt_q == '0 && !any_q)
    else $error("search state not cleared after closing triangle");

endmodule
